// File: design/asm_comment_stripper_defines.svh
// Assertion macros for the comment stripper checker.
`ifndef ASM_COMMENT_STRIPPER_DEFINES_SVH
`define ASM_COMMENT_STRIPPER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ACS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ACS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/acs_pkg.sv
// Types, byte codes and helpers shared by the comment stripper files.
package acs_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_AT    = 8'h40;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef enum logic [4:0] {
        MODE_TEXT  = 5'b00001,
        MODE_LINE  = 5'b00010,
        MODE_BLOCK = 5'b00100,
        MODE_QUOTE = 5'b01000,
        MODE_DONE  = 5'b10000
    } scan_mode_t;

    // Byte a held byte turns into when no pair forms.
    function automatic logic [7:0] held_alone(input scan_mode_t mode);
        logic [7:0] res;
        case (mode)
            MODE_TEXT:  res = CH_SLASH;
            MODE_QUOTE: res = CH_BSL;
            default:    res = CH_SPACE;
        endcase
        return res;
    endfunction

endpackage

// File: design/asm_comment_stripper.sv
// Top level of the source comment stripper: scanner and result queue.
//
// Takes one source byte per request and returns the byte stream with comments
// blanked to spaces. Line comments open at the byte in the configuration
// register (0x40 '@' after reset) unless the byte before was a backslash and
// run to the newline, which is kept. Block comments run from slash-star to
// star-slash with their inner newlines kept. Quoted text passes unchanged, and
// a zero byte ends stripping for the rest of the stream. A slash, a star in a
// block comment or a backslash in a quote is held back for one byte so the
// scanner can see what follows; the request marked last flushes it and puts
// the scanner back to its reset state for a new stream. Each input request
// yields zero, one or two result requests. The scanner decides combinationally,
// and its results land in a four-entry result queue that drives the output
// port one byte per cycle unless stalled; the first result is visible the
// cycle after its input is taken if the queue was empty. Input requests are
// taken every cycle while the queue holds at most two results, so the
// sustained rate is one input byte per cycle as long as the output keeps up;
// a request that yields two results needs two output transfers. The
// configuration port is always ready and is to be written only while idle.
module asm_comment_stripper
    import acs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  in_item_t   item,
    output logic       result_valid,
    input  logic       result_ready,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    // Scanner state.
    scan_mode_t mode_reg, mode_next;
    logic       quote_single_reg, quote_single_next;
    logic       held_reg, held_next;
    logic       prev_bsl_reg, prev_bsl_next;
    logic [7:0] lcc_reg;

    // Result queue: four entries, at most two pushed per cycle.
    out_item_t  queue_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    logic       accept;
    logic       pop;
    logic [1:0] push_n;
    logic [7:0] emit_byte0, emit_byte1;
    logic [7:0] qchar;
    logic [7:0] b;
    logic       last;

    // Fresh-byte decision.
    logic       fr_emit;
    logic [7:0] fr_byte;
    logic       fr_hold;
    scan_mode_t fr_mode;
    logic       fr_single;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (count_reg <= 3'd2);
    assign accept       = item_valid && item_ready;
    assign result_valid = (count_reg != 3'd0);
    assign result       = queue_mem[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    assign b     = item.in_byte;
    assign last  = item.in_last;
    assign qchar = quote_single_reg ? CH_SQ : CH_DQ;

    // Work out what a byte does when it is not the second half of a pair.
    always_comb
    begin
        fr_emit   = 1'b0;
        fr_byte   = b;
        fr_hold   = 1'b0;
        fr_mode   = mode_reg;
        fr_single = quote_single_reg;
        if (b == CH_NUL)
        begin
            fr_emit = 1'b1;
            fr_mode = MODE_DONE;
        end
        else
        begin
            case (mode_reg)
                MODE_LINE:
                begin
                    fr_emit = 1'b1;
                    if (b == CH_NL)
                    begin
                        fr_mode = MODE_TEXT;
                    end
                    else
                    begin
                        fr_byte = CH_SPACE;
                    end
                end
                MODE_BLOCK:
                begin
                    if (b == CH_STAR)
                    begin
                        fr_hold = 1'b1;
                    end
                    else
                    begin
                        fr_emit = 1'b1;
                        fr_byte = (b == CH_NL) ? b : CH_SPACE;
                    end
                end
                MODE_QUOTE:
                begin
                    if (b == CH_BSL)
                    begin
                        fr_hold = 1'b1;
                    end
                    else
                    begin
                        fr_emit = 1'b1;
                        if (b == qchar)
                        begin
                            fr_mode = MODE_TEXT;
                        end
                    end
                end
                MODE_DONE:
                begin
                    fr_emit = 1'b1;
                end
                default:
                begin
                    // Text; an unknown code also scans as text.
                    fr_mode = MODE_TEXT;
                    if (b == lcc_reg && !prev_bsl_reg && b != CH_NL)
                    begin
                        fr_emit = 1'b1;
                        fr_byte = CH_SPACE;
                        fr_mode = MODE_LINE;
                    end
                    else if (b == CH_SLASH)
                    begin
                        fr_hold = 1'b1;
                    end
                    else
                    begin
                        fr_emit = 1'b1;
                        if (b == CH_DQ || b == CH_SQ)
                        begin
                            fr_single = (b == CH_SQ);
                            fr_mode   = MODE_QUOTE;
                        end
                    end
                end
            endcase
        end
    end

    // Resolve a held byte, then the fresh byte, then the end-of-stream flush.
    always_comb
    begin
        scan_mode_t mode_eff;
        logic       pair;
        logic       tail;
        logic [1:0] n;

        mode_eff          = (mode_reg == MODE_LINE || mode_reg == MODE_BLOCK ||
                             mode_reg == MODE_QUOTE || mode_reg == MODE_DONE)
                            ? mode_reg : MODE_TEXT;
        n                 = 2'd0;
        emit_byte0        = CH_SPACE;
        emit_byte1        = CH_SPACE;
        pair              = 1'b0;
        tail              = 1'b0;
        mode_next         = mode_eff;
        quote_single_next = quote_single_reg;
        held_next         = 1'b0;

        if (held_reg)
        begin
            if (mode_eff == MODE_TEXT && b == CH_STAR)
            begin
                pair      = 1'b1;
                mode_next = MODE_BLOCK;
            end
            else if (mode_eff == MODE_BLOCK && b == CH_SLASH)
            begin
                pair      = 1'b1;
                mode_next = MODE_TEXT;
            end
            else if (mode_eff == MODE_QUOTE && b == qchar)
            begin
                pair       = 1'b1;
                emit_byte0 = CH_BSL;
                emit_byte1 = b;
            end
            if (pair)
            begin
                n = 2'd2;
            end
            else
            begin
                emit_byte0 = held_alone(mode_eff);
                n          = 2'd1;
            end
        end

        if (!pair)
        begin
            mode_next         = fr_mode;
            quote_single_next = fr_single;
            held_next         = fr_hold;
            if (fr_emit)
            begin
                if (n == 2'd0)
                begin
                    emit_byte0 = fr_byte;
                end
                else
                begin
                    emit_byte1 = fr_byte;
                end
                n = n + 2'd1;
            end
        end

        prev_bsl_next = (b == CH_BSL);

        if (last)
        begin
            // Flush a byte still held; it resolves as if the stream ended.
            tail = held_next;
            if (tail)
            begin
                if (n == 2'd0)
                begin
                    emit_byte0 = held_alone(mode_next);
                end
                else
                begin
                    emit_byte1 = held_alone(mode_next);
                end
                n = n + 2'd1;
            end
            mode_next         = MODE_TEXT;
            quote_single_next = 1'b0;
            held_next         = 1'b0;
            prev_bsl_next     = 1'b0;
        end

        push_n = accept ? n : 2'd0;
    end

    // Scanner and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_TEXT;
            quote_single_reg <= 1'b0;
            held_reg         <= 1'b0;
            prev_bsl_reg     <= 1'b0;
            lcc_reg          <= CH_AT;
        end
        else
        begin
            if (accept)
            begin
                mode_reg         <= mode_next;
                quote_single_reg <= quote_single_next;
                held_reg         <= held_next;
                prev_bsl_reg     <= prev_bsl_next;
            end
            if (cfg_valid)
            begin
                lcc_reg <= cfg_data;
            end
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push_n} - {2'b00, pop};
        end
    end

    // Queue payload; the last flag goes on the final result of the request.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= '{out_byte: emit_byte0,
                                       out_last: last && (push_n == 2'd1)};
        end
        if (push_n == 2'd2)
        begin
            queue_mem[wr_ptr_reg + 2'd1] <= '{out_byte: emit_byte1, out_last: last};
        end
    end

endmodule

// File: design/acs_checker.sv
// Port checker for the comment stripper and its bind to the top level.
`include "asm_comment_stripper_defines.svh"

module acs_checker
    import acs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input in_item_t   item,
    input logic       result_valid,
    input logic       result_ready,
    input out_item_t  result,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A stalled input request holds until taken.
    `ACS_ASSERT(a_item_hold, item_valid && !item_ready |=> item_valid && $stable(item), "input changed while stalled")

    // A stalled result holds until taken.
    `ACS_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

    // A result appears only after an input request was taken.
    `ACS_ASSERT(a_result_cause, !result_valid ##1 result_valid |-> $past(item_valid && item_ready), "result without input")

    // Input backpressure only while results wait in the queue.
    `ACS_ASSERT(a_ready_low, !item_ready |-> result_valid, "input stalled with empty queue")

    // Configuration writes are never refused outside reset.
    `ACS_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind asm_comment_stripper acs_checker u_acs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
